// ----- sv/bdc_pkg.sv -----
// shared types, widths and register codes of the button debounce block
package bdc_pkg;

   localparam int NUM_BUTTONS = 4;
   localparam int TIME_W      = 32;
   localparam int CFG_W       = 16;
   localparam int CSR_IDX_W   = 3;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_MS          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_PERIOD_MS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POLL_PERIOD_MS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_ENABLE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LEVELS    = 3'd5;

   // register values after reset
   localparam logic [CFG_W-1:0]       DEBOUNCE_MS_RESET      = 16'd20;
   localparam logic [CFG_W-1:0]       HOLD_MS_RESET          = 16'd1000;
   localparam logic [CFG_W-1:0]       REPEAT_PERIOD_MS_RESET = 16'd100;
   localparam logic [CFG_W-1:0]       POLL_PERIOD_MS_RESET   = 16'd5;
   localparam logic                   REPEAT_ENABLE_RESET    = 1'b0;
   localparam logic [NUM_BUTTONS-1:0] ACTIVE_LEVELS_RESET    = '0;

   typedef struct packed {
      logic [TIME_W-1:0]      now_ms;
      logic [NUM_BUTTONS-1:0] pin_levels;
      logic                   tx_enabled;
      logic                   bus_accepts;
   } bdc_req_type;

   typedef struct packed {
      logic                   polled;
      logic                   toggle_request;
      logic [NUM_BUTTONS-1:0] send_mask;
      logic [NUM_BUTTONS-1:0] stable_levels;
   } bdc_rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0]       debounce_ms;
      logic [CFG_W-1:0]       hold_ms;
      logic [CFG_W-1:0]       repeat_period_ms;
      logic [CFG_W-1:0]       poll_period_ms;
      logic                   repeat_enable;
      logic [NUM_BUTTONS-1:0] active_levels;
   } bdc_cfg_type;

   // from the control unit to every button
   typedef struct packed {
      logic polled;
      logic send_allow;
   } bdc_ctrl_type;

endpackage

// ----- sv/button_debounce_combo_tx_request.sv -----
// top level: csr registers, input register, button cells, control and result register
//
// Each req beat is one timer tick and gives exactly one rsp beat. The block takes
// one beat per clock cycle while the output register can move on (rsp_ready high
// or output empty); a beat is held in the input register, where the button cells
// and the combo/poll control evaluate it in a single combinational pass and update
// their state, and its result leaves from the output register.
// Ticks closer than poll_period_ms to the last polled tick pass through with
// polled, toggle_request and send_mask low. Registers are written through the csr
// port (index 0 debounce_ms, 1 hold_ms, 2 repeat_period_ms, 3 poll_period_ms,
// 4 repeat_enable, 5 active_levels; other indexes are ignored) and should only be
// written while no beat is in flight.
module button_debounce_combo_tx_request import bdc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bdc_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bdc_rsp_type          rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   bdc_cfg_type            cfg_ff;
   logic                   in_vld_ff;
   bdc_req_type            req_ff;
   logic                   out_vld_ff;
   bdc_rsp_type            rsp_ff, rsp_in;
   logic                   fire;
   bdc_ctrl_type           ctrl;
   logic                   toggle;
   logic [NUM_BUTTONS-1:0] pressed;
   logic [NUM_BUTTONS-1:0] send_mask;
   logic [NUM_BUTTONS-1:0] stable_levels;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms      <= DEBOUNCE_MS_RESET;
         cfg_ff.hold_ms          <= HOLD_MS_RESET;
         cfg_ff.repeat_period_ms <= REPEAT_PERIOD_MS_RESET;
         cfg_ff.poll_period_ms   <= POLL_PERIOD_MS_RESET;
         cfg_ff.repeat_enable    <= REPEAT_ENABLE_RESET;
         cfg_ff.active_levels    <= ACTIVE_LEVELS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DEBOUNCE_MS:      cfg_ff.debounce_ms      <= csr_wdata;
            CSR_HOLD_MS:          cfg_ff.hold_ms          <= csr_wdata;
            CSR_REPEAT_PERIOD_MS: cfg_ff.repeat_period_ms <= csr_wdata;
            CSR_POLL_PERIOD_MS:   cfg_ff.poll_period_ms   <= csr_wdata;
            CSR_REPEAT_ENABLE:    cfg_ff.repeat_enable    <= csr_wdata[0];
            CSR_ACTIVE_LEVELS:    cfg_ff.active_levels    <= csr_wdata[NUM_BUTTONS-1:0];
            default: ;
         endcase
      end
   end

   // handshake: the input register moves on when the output register is free
   assign fire      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   // button cells
   for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
      bdc_button u_button (
         .clock        (clock),
         .reset        (reset),
         .fire         (fire),
         .ctrl         (ctrl),
         .cfg          (cfg_ff),
         .active_level (cfg_ff.active_levels[b]),
         .now_ms       (req_ff.now_ms),
         .pin_level    (req_ff.pin_levels[b]),
         .bus_accepts  (req_ff.bus_accepts),
         .stable_level (stable_levels[b]),
         .pressed      (pressed[b]),
         .send_req     (send_mask[b])
      );
   end

   // poll gate and combo control
   bdc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .cfg        (cfg_ff),
      .now_ms     (req_ff.now_ms),
      .tx_enabled (req_ff.tx_enabled),
      .pressed0   (pressed[0]),
      .pressed1   (pressed[1]),
      .ctrl       (ctrl),
      .toggle     (toggle)
   );

   // result register
   always_comb begin
      rsp_in.polled         = ctrl.polled;
      rsp_in.toggle_request = toggle;
      rsp_in.send_mask      = send_mask;
      rsp_in.stable_levels  = stable_levels;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (fire) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_toggle_polled: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && rsp_ff.toggle_request |-> rsp_ff.polled)
      else $error("toggle on a tick that was not polled");

   a_send_polled: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && (rsp_ff.send_mask != '0) |-> rsp_ff.polled)
      else $error("send on a tick that was not polled");

   a_toggle_no_send: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && rsp_ff.toggle_request |-> (rsp_ff.send_mask == '0))
      else $error("send while the combo is held");

   a_input_kept: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !fire |=> in_vld_ff && $stable(req_ff))
      else $error("input beat lost while stalled");

endmodule

// ----- sv/bdc_button.sv -----
// one button: debounce, press edge and send / auto-repeat decision
module bdc_button import bdc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  bdc_ctrl_type      ctrl,
   input  bdc_cfg_type       cfg,
   input  logic              active_level,
   input  logic [TIME_W-1:0] now_ms,
   input  logic              pin_level,
   input  logic              bus_accepts,
   output logic              stable_level,
   output logic              pressed,
   output logic              send_req
);

   logic              raw_ff, raw_in;
   logic              stable_ff, stable_in;
   logic              seen_ff;
   logic [TIME_W-1:0] changed_ff, changed_in;
   logic [TIME_W-1:0] last_send_ff, last_send_in;

   logic              raw_moved;
   logic [TIME_W-1:0] settle_diff;
   logic              settled;
   logic              press_edge;
   logic              act;
   logic [TIME_W-1:0] send_base;
   logic [TIME_W-1:0] rep_diff;
   logic              edge_send;
   logic              rep_due;
   logic              rep_send;

   // debounce: a fresh raw change has zero age
   always_comb begin
      raw_moved   = pin_level != raw_ff;
      settle_diff = now_ms - changed_ff;
      settled     = raw_moved ? (cfg.debounce_ms == '0)
                              : (settle_diff >= TIME_W'(cfg.debounce_ms));
      press_edge  = seen_ff && (pin_level != stable_ff) && settled;
      stable_in   = (!seen_ff || press_edge) ? pin_level : stable_ff;
      raw_in      = pin_level;
      changed_in  = (!seen_ff || raw_moved) ? now_ms : changed_ff;
      act         = stable_in == active_level;
   end

   // sends: an accepted edge send restarts the repeat interval at zero
   always_comb begin
      send_base = seen_ff ? last_send_ff : '0;
      rep_diff  = now_ms - send_base;
      edge_send = ctrl.send_allow && press_edge && act;
      rep_due   = (edge_send && bus_accepts) ? (cfg.repeat_period_ms == '0)
                                             : (rep_diff >= TIME_W'(cfg.repeat_period_ms));
      rep_send  = ctrl.send_allow && cfg.repeat_enable && act && rep_due;
      send_req  = edge_send || rep_send;
      last_send_in = (send_req && bus_accepts) ? now_ms : send_base;
   end

   assign pressed      = act;
   assign stable_level = ctrl.polled ? stable_in : stable_ff;

   // per-button state, moves only on a polled beat
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff       <= 1'b0;
         stable_ff    <= 1'b0;
         seen_ff      <= 1'b0;
         changed_ff   <= '0;
         last_send_ff <= '0;
      end else if (fire && ctrl.polled) begin
         raw_ff       <= raw_in;
         stable_ff    <= stable_in;
         seen_ff      <= 1'b1;
         changed_ff   <= changed_in;
         last_send_ff <= last_send_in;
      end
   end

endmodule

// ----- sv/bdc_ctrl.sv -----
// poll gate, two-button combo timing and the send blocking after a combo
module bdc_ctrl import bdc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  bdc_cfg_type       cfg,
   input  logic [TIME_W-1:0] now_ms,
   input  logic              tx_enabled,
   input  logic              pressed0,
   input  logic              pressed1,
   output bdc_ctrl_type      ctrl,
   output logic              toggle
);

   logic [TIME_W-1:0] last_poll_ff;
   logic              held_ff, held_in;
   logic              reported_ff, reported_in;
   logic              block_ff, block_in;
   logic [TIME_W-1:0] start_ff, start_in;

   logic [TIME_W-1:0] poll_diff;
   logic              polled;
   logic              combo;
   logic [TIME_W-1:0] hold_diff;
   logic              hold_hit;

   // poll gate on wrapped time difference
   always_comb begin
      poll_diff = now_ms - last_poll_ff;
      polled    = poll_diff >= TIME_W'(cfg.poll_period_ms);
   end

   // combo: a combo that starts now has zero hold age
   always_comb begin
      combo     = pressed0 && pressed1;
      hold_diff = now_ms - start_ff;
      hold_hit  = held_ff ? (hold_diff >= TIME_W'(cfg.hold_ms)) : (cfg.hold_ms == '0);
      toggle    = polled && combo && !(held_ff && reported_ff) && hold_hit;
      held_in     = combo;
      reported_in = combo && ((held_ff && reported_ff) || toggle);
      start_in    = (combo && held_ff) ? start_ff : now_ms;
      if (combo) begin
         block_in = 1'b1;
      end else if (!pressed0 && !pressed1) begin
         block_in = 1'b0;
      end else begin
         block_in = block_ff;
      end
   end

   assign ctrl.polled     = polled;
   assign ctrl.send_allow = polled && tx_enabled && !combo && !block_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_poll_ff <= '0;
         held_ff      <= 1'b0;
         reported_ff  <= 1'b0;
         block_ff     <= 1'b0;
         start_ff     <= '0;
      end else if (fire && polled) begin
         last_poll_ff <= now_ms;
         held_ff      <= held_in;
         reported_ff  <= reported_in;
         block_ff     <= block_in;
         start_ff     <= start_in;
      end
   end

endmodule
